@@ sv/tlto_pkg.sv @@
// Shared constants, types and the arctangent table for the thick line outliner.
package tlto_pkg;

   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = 4;
   localparam int ANG_W        = 20;
   localparam int VEC_W        = 36;
   localparam int ROT_W        = 34;
   localparam int STEP_W       = 5;
   localparam int QUO_W        = 18;
   localparam int OFF_W        = 26;
   localparam int PROD_W       = 59;
   localparam int COORD_W      = 32;
   localparam int SWIDTH_W     = 24;
   localparam int CNT_W        = 5;

   localparam logic signed [ANG_W-1:0] PI_Q16      = 20'sd205887;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [ROT_W-1:0] KINV_Q30    = 34'sd652032874;

   // floor(w / 1000) for w below 32000 as (w * 33555) >> 25
   localparam logic [15:0]         RECIP_1000   = 16'd33555;
   localparam int                  RECIP_SHIFT  = 25;
   localparam logic [SWIDTH_W-1:0] WIDTH_CLAMP  = 24'd32000;
   localparam logic [CNT_W-1:0]    FRONT_LAST   = 5'd17;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [SWIDTH_W-1:0]       stroke_width;
      logic [STEP_W-1:0]         steps;
      logic signed [ANG_W-1:0]   base;
      logic [QUO_W-1:0]          pi_quo;
      logic [STEP_W-1:0]         pi_rem;
   } seg_type;

   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ITER_W-1:0] k);
      logic signed [ANG_W-1:0] v;
      case (k)
         4'd0:    v = 20'sd51472;
         4'd1:    v = 20'sd30386;
         4'd2:    v = 20'sd16055;
         4'd3:    v = 20'sd8150;
         4'd4:    v = 20'sd4091;
         4'd5:    v = 20'sd2047;
         4'd6:    v = 20'sd1024;
         4'd7:    v = 20'sd512;
         4'd8:    v = 20'sd256;
         4'd9:    v = 20'sd128;
         4'd10:   v = 20'sd64;
         4'd11:   v = 20'sd32;
         4'd12:   v = 20'sd16;
         4'd13:   v = 20'sd8;
         4'd14:   v = 20'sd4;
         default: v = 20'sd2;
      endcase
      return v;
   endfunction

endpackage

@@ sv/tlto_req_if.sv @@
// Segment request channel.
interface tlto_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [tlto_pkg::COORD_W-1:0]      start_x;
   logic signed [tlto_pkg::COORD_W-1:0]      start_y;
   logic signed [tlto_pkg::COORD_W-1:0]      end_x;
   logic signed [tlto_pkg::COORD_W-1:0]      end_y;
   logic [tlto_pkg::SWIDTH_W-1:0]            stroke_width;

   modport source (output valid, start_x, start_y, end_x, end_y, stroke_width, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, stroke_width, output ready);
endinterface

@@ sv/tlto_rsp_if.sv @@
// Outline vertex response channel.
interface tlto_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tlto_pkg::COORD_W-1:0] point_x;
   logic signed [tlto_pkg::COORD_W-1:0] point_y;
   logic                                last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

@@ sv/tlto_front.sv @@
// Front end: takes a segment, finds its direction, step count and PI/steps.
module tlto_front #(
   parameter int MAX_STEPS = 31
) (
   input  logic               clock,
   input  logic               reset,
   tlto_req_if.sink           req_ch,
   output tlto_pkg::seg_type  push_word,
   output logic               push_valid,
   input  logic               push_ready
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_RUN  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type                        state_ff, state_in;
   logic [tlto_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   tlto_pkg::seg_type                 seg_ff, seg_in;
   logic signed [tlto_pkg::VEC_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [tlto_pkg::ANG_W-1:0] vz_ff, vz_in;
   logic                              zero_ff, zero_in;
   logic [tlto_pkg::STEP_W-1:0]       rem_ff, rem_in;
   logic [tlto_pkg::QUO_W-1:0]        quo_ff, quo_in;

   logic signed [32:0]                dx, dy;
   logic signed [tlto_pkg::VEC_W-1:0] dx_ext, dy_ext, sx_sh, sy_sh;
   logic [30:0]                       n_prod;
   logic [tlto_pkg::STEP_W-1:0]       n_raw, n_sel;
   logic [tlto_pkg::STEP_W:0]         div_t;
   logic [tlto_pkg::ITER_W-1:0]       k;

   always_comb begin
      dx     = {req_ch.start_x[31], req_ch.start_x} - {req_ch.end_x[31], req_ch.end_x};
      dy     = {req_ch.start_y[31], req_ch.start_y} - {req_ch.end_y[31], req_ch.end_y};
      dx_ext = tlto_pkg::VEC_W'(dx);
      dy_ext = tlto_pkg::VEC_W'(dy);
      n_prod = 31'(req_ch.stroke_width[14:0]) * 31'(tlto_pkg::RECIP_1000);
      n_raw  = n_prod[tlto_pkg::RECIP_SHIFT +: tlto_pkg::STEP_W];
      if (req_ch.stroke_width >= tlto_pkg::WIDTH_CLAMP ||
          n_raw > tlto_pkg::STEP_W'(MAX_STEPS)) begin
         n_sel = tlto_pkg::STEP_W'(MAX_STEPS);
      end else if (n_raw < 5'd2) begin
         n_sel = 5'd2;
      end else begin
         n_sel = n_raw;
      end
      k     = cnt_ff[tlto_pkg::ITER_W-1:0];
      sx_sh = vx_ff >>> k;
      sy_sh = vy_ff >>> k;
      div_t = {rem_ff, quo_ff[tlto_pkg::QUO_W-1]};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      seg_in   = seg_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      vz_in    = vz_ff;
      zero_in  = zero_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_ch.valid && req_ch.stroke_width != '0) begin
               seg_in.start_x      = req_ch.start_x;
               seg_in.start_y      = req_ch.start_y;
               seg_in.end_x        = req_ch.end_x;
               seg_in.end_y        = req_ch.end_y;
               seg_in.stroke_width = req_ch.stroke_width;
               seg_in.steps        = n_sel;
               zero_in = (dx == '0) && (dy == '0);
               if (dx < 0) begin
                  vx_in = -dx_ext;
                  vy_in = -dy_ext;
                  vz_in = (dy >= 0) ? tlto_pkg::PI_Q16 : -tlto_pkg::PI_Q16;
               end else begin
                  vx_in = dx_ext;
                  vy_in = dy_ext;
                  vz_in = '0;
               end
               rem_in   = '0;
               quo_in   = tlto_pkg::QUO_W'(tlto_pkg::PI_Q16);
               cnt_in   = '0;
               state_in = F_RUN;
            end
         end
         F_RUN: begin
            if (cnt_ff < tlto_pkg::CNT_W'(tlto_pkg::CORDIC_ITERS)) begin
               if (vy_ff < 0) begin
                  vx_in = vx_ff - sy_sh;
                  vy_in = vy_ff + sx_sh;
                  vz_in = vz_ff - tlto_pkg::atan_q16(k);
               end else begin
                  vx_in = vx_ff + sy_sh;
                  vy_in = vy_ff - sx_sh;
                  vz_in = vz_ff + tlto_pkg::atan_q16(k);
               end
            end
            if (div_t >= {1'b0, seg_ff.steps}) begin
               rem_in = tlto_pkg::STEP_W'(div_t - {1'b0, seg_ff.steps});
               quo_in = {quo_ff[tlto_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = div_t[tlto_pkg::STEP_W-1:0];
               quo_in = {quo_ff[tlto_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == tlto_pkg::FRONT_LAST) begin
               seg_in.base   = zero_ff ? '0 : vz_ff;
               seg_in.pi_quo = quo_in;
               seg_in.pi_rem = rem_in;
               state_in      = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      seg_ff  <= seg_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      vz_ff   <= vz_in;
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign req_ch.ready = (state_ff == F_IDLE);
   assign push_valid   = (state_ff == F_PUSH);
   assign push_word    = seg_ff;

endmodule

@@ sv/tlto_queue.sv @@
// Two-entry queue of segment words between front and back.
module tlto_queue (
   input  logic              clock,
   input  logic              reset,
   input  tlto_pkg::seg_type push_word,
   input  logic              push_valid,
   output logic              push_ready,
   output tlto_pkg::seg_type pop_word,
   output logic              pop_valid,
   input  logic              pop_ready
);

   tlto_pkg::seg_type mem [2];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != 2'd2);
      pop_valid  = (count_ff != 2'd0);
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff ^ do_push;
      rd_ptr_in  = rd_ptr_ff ^ do_pop;
      count_in   = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      pop_word   = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

endmodule

@@ sv/tlto_back.sv @@
// Back end: walks the outline vertices, one rotation CORDIC per vertex.
module tlto_back (
   input  logic              clock,
   input  logic              reset,
   input  tlto_pkg::seg_type pop_word,
   input  logic              pop_valid,
   output logic              pop_ready,
   tlto_rsp_if.source        rsp_ch
);

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_SETUP = 6'b000010,
      B_ROT   = 6'b000100,
      B_MUL   = 6'b001000,
      B_OFF   = 6'b010000,
      B_EMIT  = 6'b100000
   } bstate_type;

   bstate_type                          state_ff, state_in;
   tlto_pkg::seg_type                   seg_ff, seg_in;
   logic                                half_ff, half_in;
   logic [tlto_pkg::STEP_W-1:0]         idx_ff, idx_in;
   logic [tlto_pkg::QUO_W-1:0]          q_ff, q_in;
   logic [tlto_pkg::STEP_W-1:0]         r_ff, r_in;
   logic signed [tlto_pkg::ROT_W-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic signed [tlto_pkg::ANG_W-1:0]   rz_ff, rz_in;
   logic                                neg_ff, neg_in;
   logic [tlto_pkg::ITER_W-1:0]         k_ff, k_in;
   logic signed [tlto_pkg::PROD_W-1:0]  prx_ff, prx_in, pry_ff, pry_in;
   logic signed [tlto_pkg::OFF_W-1:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic                                out_valid_ff, out_valid_in;
   logic signed [tlto_pkg::COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                                out_last_ff, out_last_in;

   logic signed [tlto_pkg::ANG_W-1:0]   phi;
   logic                                phi_neg;
   logic signed [tlto_pkg::ROT_W-1:0]   rx_sh, ry_sh, cx, cy;
   logic signed [tlto_pkg::PROD_W-1:0]  rnd_x, rnd_y;
   logic signed [tlto_pkg::COORD_W+1:0] sum_x, sum_y;
   logic signed [tlto_pkg::COORD_W-1:0] sat_x, sat_y;
   logic [tlto_pkg::STEP_W:0]           r_sum;
   logic                                carry, out_busy;

   function automatic logic signed [tlto_pkg::COORD_W-1:0] sat32(
      input logic signed [tlto_pkg::COORD_W+1:0] v);
      logic signed [tlto_pkg::COORD_W-1:0] o;
      if (v > 34'sh0_7FFF_FFFF) begin
         o = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         o = 32'sh8000_0000;
      end else begin
         o = v[tlto_pkg::COORD_W-1:0];
      end
      return o;
   endfunction

   always_comb begin
      phi     = seg_ff.base + $signed({2'b00, q_ff}) - tlto_pkg::HALF_PI_Q16;
      phi_neg = 1'b0;
      for (int j = 0; j < 3; j++) begin
         if (phi > tlto_pkg::HALF_PI_Q16) begin
            phi     = phi - tlto_pkg::PI_Q16;
            phi_neg = ~phi_neg;
         end
      end
      for (int j = 0; j < 3; j++) begin
         if (phi < -tlto_pkg::HALF_PI_Q16) begin
            phi     = phi + tlto_pkg::PI_Q16;
            phi_neg = ~phi_neg;
         end
      end
      rx_sh = rx_ff >>> k_ff;
      ry_sh = ry_ff >>> k_ff;
      cx    = neg_ff ? -rx_ff : rx_ff;
      cy    = neg_ff ? -ry_ff : ry_ff;
      rnd_x = (prx_ff + 59'sd1073741824) >>> 31;
      rnd_y = (pry_ff + 59'sd1073741824) >>> 31;
      if (half_ff) begin
         sum_x = 34'(seg_ff.end_x) - 34'(ox_ff);
         sum_y = 34'(seg_ff.end_y) - 34'(oy_ff);
      end else begin
         sum_x = 34'(seg_ff.start_x) + 34'(ox_ff);
         sum_y = 34'(seg_ff.start_y) + 34'(oy_ff);
      end
      sat_x    = sat32(sum_x);
      sat_y    = sat32(sum_y);
      r_sum    = {1'b0, r_ff} + {1'b0, seg_ff.pi_rem};
      carry    = r_sum >= {1'b0, seg_ff.steps};
      out_busy = out_valid_ff && !rsp_ch.ready;
   end

   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      half_in      = half_ff;
      idx_in       = idx_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rz_in        = rz_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      prx_in       = prx_ff;
      pry_in       = pry_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               seg_in   = pop_word;
               half_in  = 1'b0;
               idx_in   = '0;
               q_in     = '0;
               r_in     = pop_word.steps >> 1;
               state_in = B_SETUP;
            end
         end
         B_SETUP: begin
            rx_in    = tlto_pkg::KINV_Q30;
            ry_in    = '0;
            rz_in    = phi;
            neg_in   = phi_neg;
            k_in     = '0;
            state_in = B_ROT;
         end
         B_ROT: begin
            if (rz_ff >= 0) begin
               rx_in = rx_ff - ry_sh;
               ry_in = ry_ff + rx_sh;
               rz_in = rz_ff - tlto_pkg::atan_q16(k_ff);
            end else begin
               rx_in = rx_ff + ry_sh;
               ry_in = ry_ff - rx_sh;
               rz_in = rz_ff + tlto_pkg::atan_q16(k_ff);
            end
            k_in = k_ff + 4'd1;
            if (k_ff == 4'(tlto_pkg::CORDIC_ITERS - 1)) begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prx_in   = tlto_pkg::PROD_W'($signed({1'b0, seg_ff.stroke_width}))
                       * tlto_pkg::PROD_W'(cx);
            pry_in   = tlto_pkg::PROD_W'($signed({1'b0, seg_ff.stroke_width}))
                       * tlto_pkg::PROD_W'(cy);
            state_in = B_OFF;
         end
         B_OFF: begin
            ox_in    = rnd_x[tlto_pkg::OFF_W-1:0];
            oy_in    = rnd_y[tlto_pkg::OFF_W-1:0];
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (!out_busy) begin
               out_valid_in = 1'b1;
               out_x_in     = sat_x;
               out_y_in     = sat_y;
               out_last_in  = half_ff && (idx_ff == seg_ff.steps);
               if (idx_ff == seg_ff.steps) begin
                  if (half_ff) begin
                     state_in = B_IDLE;
                  end else begin
                     half_in  = 1'b1;
                     idx_in   = '0;
                     q_in     = '0;
                     r_in     = seg_ff.steps >> 1;
                     state_in = B_SETUP;
                  end
               end else begin
                  idx_in = idx_ff + 5'd1;
                  q_in   = q_ff + seg_ff.pi_quo + {17'd0, carry};
                  r_in   = carry ? tlto_pkg::STEP_W'(r_sum - {1'b0, seg_ff.steps})
                                 : r_sum[tlto_pkg::STEP_W-1:0];
                  state_in = B_SETUP;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      seg_ff      <= seg_in;
      half_ff     <= half_in;
      idx_ff      <= idx_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rz_ff       <= rz_in;
      neg_ff      <= neg_in;
      k_ff        <= k_in;
      prx_ff      <= prx_in;
      pry_ff      <= pry_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign pop_ready         = (state_ff == B_IDLE);
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.point_x    = out_x_ff;
   assign rsp_ch.point_y    = out_y_ff;
   assign rsp_ch.last_point = out_last_ff;

endmodule

@@ sv/thick_line_to_outline_unit.sv @@
// The front runs the atan2 CORDIC and the PI/steps divider, then the back works one vertex at a time.
// Each vertex runs the 16-step rotation CORDIC, a multiply, a round and a saturating add or subtract.
// A segment of n steps yields 2*(n+1) words.
// The front takes the next segment while the back works, through a two-word queue.
// Zero-width segments are taken and give no words.
// Synchronous reset clears the control state and the queue; no words are pending after it.
module thick_line_to_outline_unit #(
   parameter int MAX_STEPS = 31
) (
   input  logic        clock,
   input  logic        reset,
   tlto_req_if.sink    req_ch,
   tlto_rsp_if.source  rsp_ch
);

   tlto_pkg::seg_type push_word, pop_word;
   logic              push_valid, push_ready, pop_valid, pop_ready;

   tlto_front #(.MAX_STEPS(MAX_STEPS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_word  (push_word),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   tlto_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_word  (push_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_word   (pop_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   tlto_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_word  (pop_word),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ sv/tlto_checker.sv @@
// Port checker for the outliner, bound to the top level.
module tlto_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [tlto_pkg::SWIDTH_W-1:0]      stroke_width,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [tlto_pkg::COORD_W-1:0] point_x,
   input logic signed [tlto_pkg::COORD_W-1:0] point_y,
   input logic                               last_point
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(point_x) && $stable(point_y) && $stable(last_point))
      else $error("rsp word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && stroke_width != '0 |=> !req_ready)
      else $error("front took a new word while busy");

endmodule

bind thick_line_to_outline_unit tlto_checker u_tlto_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .stroke_width (req_ch.stroke_width),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .point_x      (rsp_ch.point_x),
   .point_y      (rsp_ch.point_y),
   .last_point   (rsp_ch.last_point)
);

@@ tb/sv/tlto_tb_if.sv @@
// Interfaces are provided by the RTL; this file holds shared testbench types.
`timescale 1ns / 100ps
package tlto_tb_pkg;
   typedef struct {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic [23:0]        stroke_width;
   } segment_type;

   typedef struct {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               last_point;
   } vertex_type;
endpackage

@@ tb/sv/testbench.sv @@
// Testbench for thick_line_to_outline_unit: stimulus, outline predictor and vertex checks.
`timescale 1ns / 100ps
module testbench;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int N_DIRECTED     = 14;
   localparam int N_RANDOM       = 200;
   localparam longint P_I        = 205887;
   localparam longint HALF_P     = 102944;
   localparam longint KINV       = 652032874;
   localparam longint STEPS_MAX  = 31;

   logic clock = 0;
   logic reset = 1;

   tlto_req_if req_ch ();
   tlto_rsp_if rsp_ch ();

   thick_line_to_outline_unit DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   tlto_tb_pkg::vertex_type expected_vertices[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   int send_idle_pct = 33;
   int recv_idle_pct = 88;

   longint arctan_q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};

   function automatic longint shr_floor(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint direction_q16(longint dy, longint dx);
      longint x, y, z, nx;
      x = dx; y = dy; z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? P_I : -P_I;
         x = -x; y = -y;
      end
      for (int k = 0; k < 16; k++) begin
         if (y < 0) begin
            nx = x - shr_floor(y, k); y = y + shr_floor(x, k); z -= arctan_q16[k];
         end else begin
            nx = x + shr_floor(y, k); y = y - shr_floor(x, k); z += arctan_q16[k];
         end
         x = nx;
      end
      return z;
   endfunction

   task automatic unit_vector(input longint phi, output longint c, output longint s);
      longint x, y, nx;
      bit neg;
      x = KINV; y = 0; neg = 0;
      while (phi > HALF_P) begin phi -= P_I; neg = !neg; end
      while (phi < -HALF_P) begin phi += P_I; neg = !neg; end
      for (int k = 0; k < 16; k++) begin
         if (phi >= 0) begin
            nx = x - shr_floor(y, k); y = y + shr_floor(x, k); phi -= arctan_q16[k];
         end else begin
            nx = x + shr_floor(y, k); y = y - shr_floor(x, k); phi += arctan_q16[k];
         end
         x = nx;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   task automatic predict_outline(input tlto_tb_pkg::segment_type seg);
      longint sx, sy, ex, ey, w, n, base, theta, c, s, ox, oy;
      int total, cnt;
      tlto_tb_pkg::vertex_type v;
      sx = longint'(seg.start_x); sy = longint'(seg.start_y);
      ex = longint'(seg.end_x); ey = longint'(seg.end_y);
      w = longint'(seg.stroke_width);
      cnt = 0;
      if (w == 0) return;
      n = w / 1000;
      if (n > STEPS_MAX) n = STEPS_MAX;
      if (n < 2) n = 2;
      total = int'(2 * (n + 1));
      base = direction_q16(sy - ey, sx - ex);
      for (int half = 0; half < 2; half++) begin
         for (longint i = 0; i <= n; i++) begin
            theta = (i * P_I + n / 2) / n - HALF_P;
            unit_vector(base + theta, c, s);
            ox = shr_floor(w * c + (64'sd1 << 30), 31);
            oy = shr_floor(w * s + (64'sd1 << 30), 31);
            if (half == 0) begin
               v.point_x = 32'(clamp32(sx + ox)); v.point_y = 32'(clamp32(sy + oy));
            end else begin
               v.point_x = 32'(clamp32(ex - ox)); v.point_y = 32'(clamp32(ey - oy));
            end
            v.last_point = (cnt == total - 1);
            expected_vertices.insert(expected_vertices.size(), v);
            cnt++;
         end
      end
   endtask

   // directed rows
   tlto_tb_pkg::segment_type directed_rows[N_DIRECTED] = '{
      '{0, 0, 1000, 0, 0},
      '{0, 0, 1000, 0, 1},
      '{0, 0, 0, 0, 2000},
      '{100, 200, -5000, 300, 999},
      '{0, 0, 0, 10000, 2999},
      '{-7, 9, 4000, -4000, 31000},
      '{0, 0, 12345, 6789, 31999},
      '{5, 5, -9000, -9000, 24'hFFFFFF},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFF00, 32'sh7FFFFF00, 24'hFFFFFF},
      '{32'sh80000000, 32'sh80000000, 32'sh80000100, 32'sh80000100, 24'hFFFFFF},
      '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 50000},
      '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 4000},
      '{-1, 0, 0, 0, 1500},
      '{0, -1, 0, 0, 2500}
   };

   task automatic send_segment(input tlto_tb_pkg::segment_type seg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.start_x <= seg.start_x; req_ch.start_y <= seg.start_y;
      req_ch.end_x <= seg.end_x; req_ch.end_y <= seg.end_y;
      req_ch.stroke_width <= seg.stroke_width;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_outline(seg);
   endtask

   function automatic tlto_tb_pkg::segment_type random_segment();
      tlto_tb_pkg::segment_type seg;
      int mode;
      mode = $urandom_range(9);
      seg.start_x = $urandom; seg.start_y = $urandom;
      if (mode < 6) begin
         seg.start_x = $signed(seg.start_x) >>> $urandom_range(31);
         seg.start_y = $signed(seg.start_y) >>> $urandom_range(31);
         seg.end_x = seg.start_x + ($signed(32'($urandom)) >>> $urandom_range(31, 8));
         seg.end_y = seg.start_y + ($signed(32'($urandom)) >>> $urandom_range(31, 8));
      end else begin
         seg.end_x = $urandom; seg.end_y = $urandom;
      end
      case ($urandom_range(9))
         0:       seg.stroke_width = 24'($urandom);
         1:       seg.stroke_width = '0;
         2:       seg.stroke_width = 24'($urandom_range(1999));
         default: seg.stroke_width = 24'($urandom_range(12000));
      endcase
      return seg;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: x=%0d y=%0d last=%0b",
                        rsp_ch.point_x, rsp_ch.point_y, rsp_ch.last_point);
         end else begin
            tlto_tb_pkg::vertex_type e;
            e = expected_vertices.pop_front();
            if (e.point_x !== rsp_ch.point_x || e.point_y !== rsp_ch.point_y ||
                e.last_point !== rsp_ch.last_point) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                           e.point_x, e.point_y, e.last_point,
                           rsp_ch.point_x, rsp_ch.point_y, rsp_ch.last_point);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("** thick_line_to_outline_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 0;
      req_ch.start_x = 0; req_ch.start_y = 0;
      req_ch.end_x = 0; req_ch.end_y = 0;
      req_ch.stroke_width = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      for (int i = 0; i < N_DIRECTED; i++) send_segment(directed_rows[i]);
      req_ch.valid <= 0;
      // hold off until the outline queue drains
      while (expected_vertices.size() != 0) @(posedge clock);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 88 : 0;
         recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 33 : 0;
         for (int i = 0; i < N_RANDOM / 3; i++) send_segment(random_segment());
      end
      req_ch.valid <= 0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** thick_line_to_outline_unit: PASSED **");
      else
         $display("** thick_line_to_outline_unit: FAILED **");
      $finish;
   end
endmodule

@@ thick_line_to_outline_unit.f @@
sv/tlto_pkg.sv
sv/tlto_req_if.sv
sv/tlto_rsp_if.sv
sv/tlto_front.sv
sv/tlto_queue.sv
sv/tlto_back.sv
sv/thick_line_to_outline_unit.sv
sv/tlto_checker.sv
tb/sv/tlto_tb_if.sv
tb/sv/testbench.sv
